// File: hw/rtl/sgcp_pkg.sv
// ----------------------------------------------------------------------------
// sgcp_pkg
// Types and constants shared by the Super-I/O configuration port modules.
// ----------------------------------------------------------------------------
package sgcp_pkg;

    localparam int unsigned NUM_PINS_DEFAULT = 8;

    // Configuration register indexes.
    localparam logic CFG_BASE_PORT = 1'b0;
    localparam logic CFG_CHIP_ID   = 1'b1;

    localparam logic [15:0] BASE_PORT_RESET = 16'h002E;
    localparam logic [15:0] CHIP_ID_RESET   = 16'hD282;

    // Access kinds.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Keys written to the index port.
    localparam logic [7:0] KEY_UNLOCK = 8'h87;
    localparam logic [7:0] KEY_LOCK   = 8'hAA;

    // Configuration space register indexes.
    localparam logic [7:0] REG_LDSEL  = 8'h07;
    localparam logic [7:0] REG_ID_HI  = 8'h20;
    localparam logic [7:0] REG_ID_LO  = 8'h21;
    localparam logic [7:0] REG_ENABLE = 8'h30;
    localparam logic [7:0] REG_DIR    = 8'hF0;
    localparam logic [7:0] REG_DATA   = 8'hF1;

    localparam logic [7:0] LD_GPIO    = 8'h07;
    localparam int unsigned ENABLE_BIT = 4;
    localparam logic [7:0] NO_DATA    = 8'hFF;

    typedef enum logic [1:0] {
        KEY_LOCKED = 2'd0,
        KEY_ONE    = 2'd1,
        KEY_OPEN   = 2'd2
    } t_key_stage;

    typedef struct packed {
        logic [15:0] io_address;
        logic        opcode;
        logic [7:0]  wr_data;
        logic [7:0]  pin_levels;
    } t_item;

    typedef struct packed {
        logic       hit;
        logic [7:0] rd_data;
        logic [7:0] pin_drive;
        logic [7:0] pin_output_enable;
        logic       config_unlocked;
    } t_result;

endpackage

// File: hw/rtl/sgcp_core.sv
// ----------------------------------------------------------------------------
// sgcp_core
// Key sequencer, configuration space registers and read decode.
// ----------------------------------------------------------------------------
module sgcp_core #(
    parameter int unsigned NUM_PINS = sgcp_pkg::NUM_PINS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  sgcp_pkg::t_item   i_item,
    input  logic [15:0]       i_base_port,
    input  logic [15:0]       i_chip_id,
    output sgcp_pkg::t_result o_result
);
    import sgcp_pkg::*;

    localparam logic [7:0] PIN_MASK = 8'((1 << NUM_PINS) - 1);

    t_key_stage r_key, n_key;
    logic [7:0] r_index, n_index;
    logic [7:0] r_dev, n_dev;
    logic [7:0] r_enable, n_enable;
    logic [7:0] r_dir, n_dir;
    logic [7:0] r_latch, n_latch;

    logic [15:0] data_port;
    logic        at_index;
    logic        at_data;
    logic        unlocked;
    logic        gpio;
    logic        is_wr;
    logic [7:0]  rd;
    logic [7:0]  reg_rd;

    assign data_port = i_base_port + 16'd1;
    assign at_index  = (i_item.io_address == i_base_port);
    assign at_data   = !at_index && (i_item.io_address == data_port);
    assign unlocked  = (r_key == KEY_OPEN);
    assign gpio      = (r_dev == LD_GPIO);
    assign is_wr     = (i_item.opcode == OP_WRITE);

    always_comb begin
        case (r_index)
            REG_LDSEL:  reg_rd = r_dev;
            REG_ID_HI:  reg_rd = i_chip_id[15:8];
            REG_ID_LO:  reg_rd = i_chip_id[7:0];
            REG_ENABLE: reg_rd = gpio ? r_enable : NO_DATA;
            REG_DIR:    reg_rd = gpio ? r_dir : NO_DATA;
            REG_DATA:   reg_rd = gpio ? (((r_dir & i_item.pin_levels) |
                                          (~r_dir & r_latch)) & PIN_MASK) : NO_DATA;
            default:    reg_rd = NO_DATA;
        endcase
    end

    always_comb begin
        n_key    = r_key;
        n_index  = r_index;
        n_dev    = r_dev;
        n_enable = r_enable;
        n_dir    = r_dir;
        n_latch  = r_latch;
        rd       = NO_DATA;
        if (at_index) begin
            if (is_wr) begin
                if (unlocked) begin
                    if (i_item.wr_data == KEY_LOCK) begin
                        n_key = KEY_LOCKED;
                    end else begin
                        n_index = i_item.wr_data;
                    end
                end else if (r_key == KEY_ONE) begin
                    n_key = (i_item.wr_data == KEY_UNLOCK) ? KEY_OPEN : KEY_LOCKED;
                end else begin
                    n_key = (i_item.wr_data == KEY_UNLOCK) ? KEY_ONE : KEY_LOCKED;
                end
            end else if (unlocked) begin
                rd = r_index;
            end
        end else if (at_data && unlocked) begin
            if (is_wr) begin
                case (r_index)
                    REG_LDSEL:  n_dev = i_item.wr_data;
                    REG_ENABLE: if (gpio) n_enable = i_item.wr_data;
                    REG_DIR:    if (gpio) n_dir = i_item.wr_data | ~PIN_MASK;
                    REG_DATA:   if (gpio) n_latch = i_item.wr_data & PIN_MASK;
                    default: ;
                endcase
            end else begin
                rd = reg_rd;
            end
        end
    end

    // The pin outputs and lock flag show the state after this access.
    always_comb begin
        o_result.hit               = at_index || at_data;
        o_result.rd_data           = rd;
        o_result.pin_drive         = n_latch & PIN_MASK;
        o_result.pin_output_enable = n_enable[ENABLE_BIT] ? (~n_dir & PIN_MASK) : 8'h00;
        o_result.config_unlocked   = (n_key == KEY_OPEN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key    <= KEY_LOCKED;
            r_index  <= 8'h00;
            r_dev    <= 8'h00;
            r_enable <= 8'h00;
            r_dir    <= 8'hFF;
            r_latch  <= 8'h00;
        end else if (i_step) begin
            r_key    <= n_key;
            r_index  <= n_index;
            r_dev    <= n_dev;
            r_enable <= n_enable;
            r_dir    <= n_dir;
            r_latch  <= n_latch;
        end
    end

    a_dir_unused_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dir | PIN_MASK) == 8'hFF)
        else $error("direction bit of an absent pin cleared");

    a_latch_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_latch & ~PIN_MASK) == 8'h00)
        else $error("latch bit of an absent pin set");

    a_miss_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !o_result.hit) |=> ($stable(r_key) && $stable(r_index) &&
                                        $stable(r_dev) && $stable(r_latch)))
        else $error("state changed on an access that missed the ports");

endmodule

// File: hw/rtl/superio_gpio_config_port_unit.sv
// ----------------------------------------------------------------------------
// superio_gpio_config_port_unit
// Super-I/O index/data configuration port with one GPIO logical device.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready   | io_address, opcode, ...
//  out     | output    | o_out_valid / i_out_ready | hit, rd_data, pin state
//  cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One access per cycle is sustained while the output is not stalled. An access
// is first taken into the input register and then decoded into the result
// register once the output can advance, where it is offered on the output.
// The configuration state is updated as the access moves into the result
// register. A stalled output holds one result while the input register takes
// one more access. Reset is synchronous and needs no clearing time.
// ----------------------------------------------------------------------------
module superio_gpio_config_port_unit #(
    parameter int unsigned NUM_PINS = sgcp_pkg::NUM_PINS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_io_address,
    input  logic        i_opcode,
    input  logic [7:0]  i_wr_data,
    input  logic [7:0]  i_pin_levels,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_hit,
    output logic [7:0]  o_rd_data,
    output logic [7:0]  o_pin_drive,
    output logic [7:0]  o_pin_output_enable,
    output logic        o_config_unlocked,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import sgcp_pkg::*;

    logic [15:0] r_base_port;
    logic [15:0] r_chip_id;
    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    t_result     r_out;
    t_result     result;
    logic        advance;
    logic        step;

    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_port <= BASE_PORT_RESET;
            r_chip_id   <= CHIP_ID_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE_PORT: r_base_port <= i_cfg_data;
                CFG_CHIP_ID:   r_chip_id   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.io_address <= i_io_address;
            r_in.opcode     <= i_opcode;
            r_in.wr_data    <= i_wr_data;
            r_in.pin_levels <= i_pin_levels;
        end
        if (step) begin
            r_out <= result;
        end
    end

    sgcp_core #(
        .NUM_PINS (NUM_PINS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in),
        .i_base_port (r_base_port),
        .i_chip_id   (r_chip_id),
        .o_result    (result)
    );

    assign o_out_valid         = r_out_valid;
    assign o_hit               = r_out.hit;
    assign o_rd_data           = r_out.rd_data;
    assign o_pin_drive         = r_out.pin_drive;
    assign o_pin_output_enable = r_out.pin_output_enable;
    assign o_config_unlocked   = r_out.config_unlocked;

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while both stages are held");

    a_step_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("advanced item did not reach the result register");

    a_held_input_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("stalled access lost from the input register");

endmodule
